// ===== hdl/pmd_pkg.sv =====
// Shared types and constants for the PID motor drive with speed limit.
// Used by the channel interfaces, the register bank and the top level.
package pmd_pkg;

    // field widths
    localparam int POS_W      = 32;
    localparam int SPEED_W    = 16;
    localparam int DRIVE_W    = 9;
    localparam int GAIN_W     = 16;
    localparam int SLIMIT_W   = 15;
    localparam int DLIMIT_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // integral accumulator
    localparam int SUM_WIDTH = 48;
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam int SUM_LO_W  = SUM_WIDTH / 2;
    localparam int SUM_HI_W  = SUM_WIDTH - SUM_LO_W;

    // position error and integral clear threshold
    localparam int ERR_W = POS_W + 1;
    localparam int ACC_W = ((SUM_WIDTH > ERR_W) ? SUM_WIDTH : ERR_W) + 1;
    localparam logic signed [ERR_W-1:0] ERR_CLEAR_MAX = ERR_W'(3);

    // term widths
    localparam int P_W      = GAIN_W + 1 + ERR_W;
    localparam int I_W      = GAIN_W + SUM_WIDTH;
    localparam int ILO_W    = GAIN_W + SUM_LO_W;
    localparam int IHI_W    = GAIN_W + SUM_HI_W;
    localparam int SPD_X_W  = SPEED_W + 1;
    localparam int SC_W     = 2 * SPD_X_W;
    localparam int DX_W     = GAIN_W + SPEED_W;
    localparam int T_W      = P_W + 1;
    localparam int DRV_W    = ((I_W > T_W) ? I_W : T_W) + 2;

    // truncating divide by 100 of a magnitude below 2^32: (n * M) >> 37
    localparam int DIVISOR_HUNDRED = 100;
    localparam logic [DX_W-1:0] DIV_MUL = 32'h51EB_851F;
    localparam int DIV_SHIFT = 37;
    localparam int DPROD_W   = 2 * DX_W;
    localparam int DQ_W      = DPROD_W - DIV_SHIFT + 1;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN    = 3'd0,
        CFG_DERIV_GAIN   = 3'd1,
        CFG_INTEG_GAIN   = 3'd2,
        CFG_SPEED_GAIN   = 3'd3,
        CFG_SPEED_LIMIT  = 3'd4,
        CFG_DRIVE_LIMIT  = 3'd5,
        CFG_DERIV_ENABLE = 3'd6
    } t_cfg_idx;

    // register bank contents
    typedef struct packed {
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   deriv_gain;
        logic [GAIN_W-1:0]   integ_gain;
        logic [GAIN_W-1:0]   speed_gain;
        logic [SLIMIT_W-1:0] speed_limit;
        logic [DLIMIT_W-1:0] drive_limit;
        logic                deriv_enable;
    } t_cfg;

endpackage

// ===== hdl/pmd_sample_if.sv =====
// Sample channel: target position, measured position and measured speed.
// Depends on pmd_pkg for the field widths.
interface pmd_sample_if;
    import pmd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   target_pos;
    logic signed [POS_W-1:0]   measured_pos;
    logic signed [SPEED_W-1:0] measured_speed;

    modport source (output valid, target_pos, measured_pos, measured_speed, input ready);
    modport sink   (input valid, target_pos, measured_pos, measured_speed, output ready);
endinterface

// ===== hdl/pmd_drive_if.sv =====
// Drive channel: one signed motor command per sample.
// Depends on pmd_pkg for the field width.
interface pmd_drive_if;
    import pmd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;

    modport source (output valid, drive, input ready);
    modport sink   (input valid, drive, output ready);
endinterface

// ===== hdl/pid_motor_drive_with_speed_limit.sv =====
// Top level of the PID motor drive with speed limit: pipeline and handshakes.
// Depends on pmd_pkg, pmd_sample_if, pmd_drive_if and pmd_cfg_regs.
//
//  channel    | dir | payload                                      | beat when
//  -----------+-----+----------------------------------------------+----------------
//  i_sample   | in  | target_pos, measured_pos, measured_speed     | valid & ready
//  o_drive    | out | drive (9 bit signed)                         | valid & ready
//  i_cfg_*    | in  | i_cfg_idx, i_cfg_data                        | i_cfg_we
//
// One sample is taken every cycle unless the pipeline is stalled; each drive value
// passes stages A to E and the output stage. The integral update (one wide add and
// saturate) is the only loop; the multiplies and the divide by 100 are pipelined.
// Reset clears the registers, the integral and all stage valid bits.
// Each stage holds while the one after it is full and stalled, so a waiting
// result backs the pipeline up one stage at a time before ready drops.
module pid_motor_drive_with_speed_limit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pmd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pmd_sample_if.sink                     i_sample,
    pmd_drive_if.source                    o_drive
);
    import pmd_pkg::*;

    t_cfg w_cfg;

    pmd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // stage valid bits and per-stage advance
    logic r_v_a, r_v_b, r_v_c, r_v_d, r_v_e, r_v_o;
    logic w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d, w_rdy_e, w_rdy_o;

    assign w_rdy_o = !r_v_o || o_drive.ready;
    assign w_rdy_e = !r_v_e || w_rdy_o;
    assign w_rdy_d = !r_v_d || w_rdy_e;
    assign w_rdy_c = !r_v_c || w_rdy_d;
    assign w_rdy_b = !r_v_b || w_rdy_c;
    assign w_rdy_a = !r_v_a || w_rdy_b;

    assign i_sample.ready = w_rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
            r_v_c <= 1'b0;
            r_v_d <= 1'b0;
            r_v_e <= 1'b0;
            r_v_o <= 1'b0;
        end else begin
            if (w_rdy_a) r_v_a <= i_sample.valid;
            if (w_rdy_b) r_v_b <= r_v_a;
            if (w_rdy_c) r_v_c <= r_v_b;
            if (w_rdy_d) r_v_d <= r_v_c;
            if (w_rdy_e) r_v_e <= r_v_d;
            if (w_rdy_o) r_v_o <= r_v_e;
        end
    end

    // stage A: input register
    logic signed [POS_W-1:0]   r_tgt_a, r_pos_a;
    logic signed [SPEED_W-1:0] r_spd_a;

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_tgt_a <= i_sample.target_pos;
            r_pos_a <= i_sample.measured_pos;
            r_spd_a <= i_sample.measured_speed;
        end
    end

    // stage B: error, integral update, damping product, overspeed term
    logic signed [ERR_W-1:0]   w_err;
    logic [ACC_W-1:0]          w_acc;
    logic [SUM_WIDTH-1:0]      n_error_sum, r_error_sum;
    logic signed [SPD_X_W-1:0] w_spd_x, w_lim_x;
    logic signed [DX_W-1:0]    w_dx;
    logic signed [SC_W-1:0]    w_sc;
    logic signed [ERR_W-1:0]   r_err_b;
    logic signed [DX_W-1:0]    r_dx_b;
    logic signed [SC_W-1:0]    r_sc_b;

    always_comb begin
        w_err = ERR_W'(r_tgt_a) - ERR_W'(r_pos_a);
        w_acc = ACC_W'(r_error_sum) + ACC_W'(w_err[ERR_W-2:0]);
        // clear on small or negative error, else add and saturate
        if (w_err <= ERR_CLEAR_MAX) begin
            n_error_sum = '0;
        end else if (w_acc > ACC_W'(SUM_MAX)) begin
            n_error_sum = SUM_MAX;
        end else begin
            n_error_sum = w_acc[SUM_WIDTH-1:0];
        end

        w_dx = w_cfg.deriv_enable
             ? DX_W'(signed'({1'b0, w_cfg.deriv_gain})) * DX_W'(r_spd_a)
             : '0;

        w_spd_x = SPD_X_W'(r_spd_a);
        w_lim_x = signed'({2'b00, w_cfg.speed_limit});
        w_sc = (w_spd_x > w_lim_x)
             ? SC_W'(signed'({1'b0, w_cfg.speed_gain})) * SC_W'(w_lim_x - w_spd_x)
             : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum <= '0;
        end else if (w_rdy_b && r_v_a) begin
            r_error_sum <= n_error_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_b) begin
            r_err_b <= w_err;
            r_dx_b  <= w_dx;
            r_sc_b  <= w_sc;
        end
    end

    // stage C: proportional product, integral partials, reciprocal multiply
    logic signed [P_W-1:0]             w_p;
    logic [DX_W-1:0]                   w_dmag;
    logic signed [P_W-1:0]             r_p_c;
    logic [ILO_W-1:0]                  r_ilo_c;
    logic [IHI_W-1:0]                  r_ihi_c;
    logic [DPROD_W-1:0]                r_dprod_c;
    logic                              r_dneg_c;
    logic signed [SC_W-1:0]            r_sc_c;

    assign w_p    = P_W'(signed'({1'b0, w_cfg.prop_gain})) * P_W'(r_err_b);
    assign w_dmag = r_dx_b[DX_W-1] ? DX_W'(-r_dx_b) : DX_W'(r_dx_b);

    always_ff @(posedge i_clk) begin
        if (w_rdy_c) begin
            r_p_c     <= w_p;
            r_ilo_c   <= ILO_W'(w_cfg.integ_gain) * ILO_W'(r_error_sum[SUM_LO_W-1:0]);
            r_ihi_c   <= IHI_W'(w_cfg.integ_gain)
                       * IHI_W'(r_error_sum[SUM_WIDTH-1:SUM_LO_W]);
            r_dprod_c <= DPROD_W'(w_dmag) * DPROD_W'(DIV_MUL);
            r_dneg_c  <= r_dx_b[DX_W-1];
            r_sc_c    <= r_sc_b;
        end
    end

    // stage D: combine integral partials, finish divide with sign
    logic [I_W-1:0]         w_i;
    logic signed [DQ_W-1:0] w_dq;
    logic signed [P_W-1:0]  r_p_d;
    logic [I_W-1:0]         r_i_d;
    logic signed [DQ_W-1:0] r_dq_d;
    logic signed [SC_W-1:0] r_sc_d;

    always_comb begin
        w_i  = (I_W'(r_ihi_c) << SUM_LO_W) + I_W'(r_ilo_c);
        w_dq = signed'({1'b0, r_dprod_c[DIV_SHIFT +: DQ_W-1]});
        if (r_dneg_c) begin
            w_dq = -w_dq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_d) begin
            r_p_d  <= r_p_c;
            r_i_d  <= w_i;
            r_dq_d <= w_dq;
            r_sc_d <= r_sc_c;
        end
    end

    // stage E: proportional minus damping plus overspeed
    logic signed [T_W-1:0] r_t1_e;
    logic [I_W-1:0]        r_i_e;

    always_ff @(posedge i_clk) begin
        if (w_rdy_e) begin
            r_t1_e <= T_W'(r_p_d) - T_W'(r_dq_d) + T_W'(r_sc_d);
            r_i_e  <= r_i_d;
        end
    end

    // output stage: subtract integral term and clamp to the drive limit
    logic signed [DRV_W-1:0]   w_drv, w_lim;
    logic signed [DRIVE_W-1:0] n_drive, r_drive_o;

    always_comb begin
        w_drv = DRV_W'(r_t1_e) - signed'(DRV_W'(r_i_e));
        w_lim = signed'(DRV_W'(w_cfg.drive_limit));
        if (w_drv > w_lim) begin
            n_drive = DRIVE_W'(w_lim);
        end else if (w_drv < -w_lim) begin
            n_drive = DRIVE_W'(-w_lim);
        end else begin
            n_drive = DRIVE_W'(w_drv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_o) begin
            r_drive_o <= n_drive;
        end
    end

    assign o_drive.valid = r_v_o;
    assign o_drive.drive = r_drive_o;
endmodule

// ===== hdl/pmd_cfg_regs.sv =====
// Configuration register bank: gains, limits and the damping enable.
// Depends on pmd_pkg for the register indexes and the t_cfg struct.
module pmd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [pmd_pkg::CFG_IDX_W-1:0]  i_idx,
    input  logic [pmd_pkg::CFG_DATA_W-1:0] i_data,
    output pmd_pkg::t_cfg                  o_cfg
);
    import pmd_pkg::*;

    t_cfg r_cfg;

    // write one register; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_we) begin
            case (t_cfg_idx'(i_idx))
                CFG_PROP_GAIN:    r_cfg.prop_gain    <= i_data[GAIN_W-1:0];
                CFG_DERIV_GAIN:   r_cfg.deriv_gain   <= i_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:   r_cfg.integ_gain   <= i_data[GAIN_W-1:0];
                CFG_SPEED_GAIN:   r_cfg.speed_gain   <= i_data[GAIN_W-1:0];
                CFG_SPEED_LIMIT:  r_cfg.speed_limit  <= i_data[SLIMIT_W-1:0];
                CFG_DRIVE_LIMIT:  r_cfg.drive_limit  <= i_data[DLIMIT_W-1:0];
                CFG_DERIV_ENABLE: r_cfg.deriv_enable <= i_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== tb/pid_motor_drive_with_speed_limit_test.sv =====
// Self-checking testbench for pid_motor_drive_with_speed_limit.
// Drives samples over pmd_sample_if, checks drive beats on pmd_drive_if against an
// in-bench predictor of the control law; depends on pmd_pkg and both channel interfaces.
module pid_motor_drive_with_speed_limit_test;
    import pmd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam logic signed [POS_W-1:0]   POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0]   POS_MIN = 32'sh8000_0000;
    localparam logic signed [SPEED_W-1:0] SPD_MAX = 16'sh7FFF;
    localparam logic signed [SPEED_W-1:0] SPD_MIN = 16'sh8000;
    localparam longint INTEG_ACC_MAX  = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
    localparam longint INTEG_TERM_CAP = longint'(1) <<< 62;
    localparam longint CLEAR_LEVEL    = 3;
    localparam longint DAMP_DIVISOR   = 100;
    localparam int DRAIN_CYCLES    = 12;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int GROW_ITEMS      = 32;
    localparam int RAND_PHASES     = 6;
    localparam int RAND_PER_PHASE  = 195;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    pmd_sample_if smp ();
    pmd_drive_if  drv ();

    pid_motor_drive_with_speed_limit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_sample   (smp),
        .o_drive    (drv)
    );

    always #2 i_clk = ~i_clk;

    // register mirror, integral state and pending drive values
    t_cfg   reg_mirror = '0;
    longint integ_acc  = 0;
    logic signed [DRIVE_W-1:0] drive_expected[$];

    // stimulus pacing and bookkeeping
    bit     tx_paced   = 1'b1;
    int     burst_left = 0;
    bit     rx_free    = 1'b0;
    int     rx_hold    = 0;
    longint approach_err  = 0;
    int     approach_left = 0;
    int     failures       = 0;
    int     samples_sent   = 0;
    int     drives_checked = 0;
    int     configs_written = 0;

    // control law for one sample: update the integral, sum the terms, clamp
    function automatic logic signed [DRIVE_W-1:0] predict_drive(
        input logic signed [POS_W-1:0] tgt, input logic signed [POS_W-1:0] pos,
        input logic signed [SPEED_W-1:0] spd);
        longint err, speed, kp, kd, ki, ks, slim, lim, p_term, d_term, i_term, raw;
        err   = longint'(tgt) - longint'(pos);
        speed = longint'(spd);
        kp    = longint'(reg_mirror.prop_gain);
        kd    = longint'(reg_mirror.deriv_gain);
        ki    = longint'(reg_mirror.integ_gain);
        ks    = longint'(reg_mirror.speed_gain);
        slim  = longint'(reg_mirror.speed_limit);
        lim   = longint'(reg_mirror.drive_limit);
        if (err <= CLEAR_LEVEL) begin
            integ_acc = 0;
        end else if (integ_acc > INTEG_ACC_MAX - err) begin
            integ_acc = INTEG_ACC_MAX;
        end else begin
            integ_acc = integ_acc + err;
        end
        p_term = kp * err;
        d_term = reg_mirror.deriv_enable ? (kd * speed) / DAMP_DIVISOR : 0;
        if (ki != 0 && integ_acc > INTEG_TERM_CAP / ki) begin
            i_term = INTEG_TERM_CAP;
        end else begin
            i_term = ki * integ_acc;
        end
        raw = p_term - d_term - i_term;
        if (speed > slim) begin
            raw = raw + ks * (slim - speed);
        end
        if (raw > lim) begin
            raw = lim;
        end else if (raw < -lim) begin
            raw = -lim;
        end
        return DRIVE_W'(raw);
    endfunction

    function automatic t_cfg make_cfg(input int kp, input int kd, input int ki, input int ks,
                                      input int slim, input int dlim, input int en);
        t_cfg c;
        c.prop_gain    = GAIN_W'(kp);
        c.deriv_gain   = GAIN_W'(kd);
        c.integ_gain   = GAIN_W'(ki);
        c.speed_gain   = GAIN_W'(ks);
        c.speed_limit  = SLIMIT_W'(slim);
        c.drive_limit  = DLIMIT_W'(dlim);
        c.deriv_enable = en[0];
        return c;
    endfunction

    // mostly small gains so that drive values often stay inside the clamp
    function automatic t_cfg rand_cfg();
        t_cfg c;
        c.prop_gain    = ($urandom_range(0, 5) == 0) ? GAIN_W'($urandom)
                                                     : GAIN_W'($urandom_range(0, 3));
        c.deriv_gain   = GAIN_W'($urandom);
        c.integ_gain   = ($urandom_range(0, 5) == 0) ? GAIN_W'($urandom)
                                                     : GAIN_W'($urandom_range(0, 2));
        c.speed_gain   = ($urandom_range(0, 5) == 0) ? GAIN_W'($urandom)
                                                     : GAIN_W'($urandom_range(0, 8));
        c.speed_limit  = SLIMIT_W'($urandom);
        c.drive_limit  = DLIMIT_W'($urandom);
        c.deriv_enable = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // mirror a register write, masked to the register width
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_PROP_GAIN:    reg_mirror.prop_gain    = data;
            CFG_DERIV_GAIN:   reg_mirror.deriv_gain   = data;
            CFG_INTEG_GAIN:   reg_mirror.integ_gain   = data;
            CFG_SPEED_GAIN:   reg_mirror.speed_gain   = data;
            CFG_SPEED_LIMIT:  reg_mirror.speed_limit  = data[SLIMIT_W-1:0];
            CFG_DRIVE_LIMIT:  reg_mirror.drive_limit  = data[DLIMIT_W-1:0];
            CFG_DERIV_ENABLE: reg_mirror.deriv_enable = data[0];
            default: ;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        apply_reg(idx, data);
    endtask

    // write every register; fill unused upper bits with noise when asked
    task automatic write_config(input t_cfg c, input bit noise);
        logic [CFG_DATA_W-1:0] fill;
        fill = noise ? CFG_DATA_W'($urandom) : '0;
        write_reg(CFG_PROP_GAIN,    c.prop_gain);
        write_reg(CFG_DERIV_GAIN,   c.deriv_gain);
        write_reg(CFG_INTEG_GAIN,   c.integ_gain);
        write_reg(CFG_SPEED_GAIN,   c.speed_gain);
        write_reg(CFG_SPEED_LIMIT,  {fill[15], c.speed_limit});
        write_reg(CFG_DRIVE_LIMIT,  {fill[15:8], c.drive_limit});
        write_reg(CFG_DERIV_ENABLE, {fill[15:1], c.deriv_enable});
        write_reg(CFG_IDX_SPARE,    CFG_DATA_W'($urandom));
        @(negedge i_clk);
        cfg_we <= 1'b0;
        configs_written++;
    endtask

    task automatic finish_stream();
        @(negedge i_clk);
        smp.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (drive_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // registers change only with the block idle
    task automatic reconfigure(input t_cfg c, input bit noise);
        finish_stream();
        wait_drained();
        write_config(c, noise);
    endtask

    // send one sample beat, with random bursts and gaps when paced
    task automatic send_sample(input logic signed [POS_W-1:0] tgt,
                               input logic signed [POS_W-1:0] pos,
                               input logic signed [SPEED_W-1:0] spd);
        int gap;
        if (tx_paced) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 7);
                if (gap > 0) begin
                    @(negedge i_clk);
                    smp.valid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 12);
            end
            burst_left--;
        end
        @(negedge i_clk);
        smp.valid          <= 1'b1;
        smp.target_pos     <= tgt;
        smp.measured_pos   <= pos;
        smp.measured_speed <= spd;
        do @(posedge i_clk); while (!smp.ready);
        drive_expected.push_back(predict_drive(tgt, pos, spd));
        samples_sent++;
    endtask

    // random sample: approach runs, threshold band, moderate and full-range errors
    task automatic rand_sample(output logic signed [POS_W-1:0] tgt,
                               output logic signed [POS_W-1:0] pos,
                               output logic signed [SPEED_W-1:0] spd);
        int pick;
        longint err, base, sv;
        pick = $urandom_range(0, 99);
        err  = 0;
        if (pick < 50) begin
            if (approach_left == 0) begin
                approach_err  = $urandom_range(4, 5000);
                approach_left = $urandom_range(4, 40);
            end
            err = approach_err;
            approach_left--;
            approach_err -= (approach_err > 8) ? $urandom_range(0, int'(approach_err / 4))
                                               : $urandom_range(0, 3);
        end else if (pick < 65) begin
            err = longint'($urandom_range(0, 12)) - 4;
        end else if (pick < 80) begin
            err = longint'($urandom_range(0, 2 ** 21)) - 2 ** 20;
        end
        if (pick >= 80) begin
            tgt = POS_W'($urandom);
            pos = POS_W'($urandom);
        end else begin
            base = longint'(int'($urandom)) >>> 1;
            pos  = POS_W'(base);
            tgt  = POS_W'(base + err);
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            sv = longint'(reg_mirror.speed_limit) + $urandom_range(0, 8) - 4;
            if (sv > 32767) sv = 32767;
            spd = SPEED_W'(sv);
        end else if (pick < 75) begin
            spd = SPEED_W'(int'($urandom_range(0, 600)) - 300);
        end else begin
            spd = SPEED_W'($urandom);
        end
    endtask

    // check each drive beat against the oldest pending value
    always @(posedge i_clk) begin : check_drive
        logic signed [DRIVE_W-1:0] want;
        if (i_rst_n && drv.valid && drv.ready) begin
            if (drive_expected.size() == 0) begin
                $error("drive: unexpected beat, actual %0d", drv.drive);
                failures++;
            end else begin
                want = drive_expected.pop_front();
                if (drv.drive !== want) begin
                    $error("drive: expected %0d, actual %0d", want, drv.drive);
                    failures++;
                end
                drives_checked++;
            end
        end
    end

    // receiver: random ready pattern, long clean runs, and forced hold-offs
    initial begin : drive_receiver
        bit level;
        int run;
        drv.ready = 1'b0;
        level = 1'b1;
        run   = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                drv.ready <= 1'b0;
                rx_hold--;
            end else if (rx_free) begin
                drv.ready <= 1'b1;
            end else begin
                if (run == 0) begin
                    level = !level;
                    if (level) begin
                        run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(1, 24);
                    end else begin
                        run = $urandom_range(1, 5);
                    end
                end
                run--;
                drv.ready <= level;
            end
        end
    end

    // end the run when no beat moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((smp.valid && smp.ready) || (drv.valid && drv.ready) || cfg_we) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("pid_motor_drive_with_speed_limit_test: FAIL");
        $finish;
    end

    // reset values: every limit is zero, so every drive is zero
    task automatic test_reset_defaults();
        send_sample(POS_MAX, POS_MIN, SPD_MAX);
        send_sample(POS_MIN, POS_MAX, SPD_MIN);
        send_sample(0, 0, 0);
        send_sample(5, 0, 1);
    endtask

    // proportional term, clear threshold and the 33-bit error
    task automatic test_prop_term();
        reconfigure(make_cfg(1, 0, 0, 0, 32767, 255, 0), 1'b1);
        send_sample(3, 0, 0);
        send_sample(-4, 0, 0);
        send_sample(200, -55, 0);
        send_sample(-300, 0, 0);
        send_sample(POS_MAX, POS_MIN, 0);
        send_sample(POS_MIN, POS_MAX, 0);
    endtask

    // speed damping: truncation toward zero, extremes, enable off
    task automatic test_damping_term();
        reconfigure(make_cfg(0, 150, 0, 0, 32767, 255, 1), 1'b0);
        send_sample(0, 0, 1);
        send_sample(0, 0, -1);
        send_sample(0, 0, -99);
        send_sample(0, 0, SPD_MAX);
        send_sample(0, 0, SPD_MIN);
        reconfigure(make_cfg(0, 150, 0, 0, 32767, 255, 0), 1'b1);
        send_sample(0, 0, SPD_MAX);
    endtask

    // overspeed correction at, just over and far over the limit
    task automatic test_overspeed_term();
        reconfigure(make_cfg(0, 0, 0, 1, 100, 255, 0), 1'b0);
        send_sample(0, 0, 100);
        send_sample(0, 0, 101);
        send_sample(0, 0, SPD_MAX);
        send_sample(0, 0, SPD_MIN);
        reconfigure(make_cfg(0, 0, 0, 65535, 0, 255, 0), 1'b0);
        send_sample(0, 0, 1);
        reconfigure(make_cfg(0, 0, 0, 65535, 32767, 255, 0), 1'b0);
        send_sample(0, 0, SPD_MAX);
    endtask

    // integral accumulates above the threshold and clears at or below it
    task automatic test_integral_clear();
        reconfigure(make_cfg(0, 0, 1, 0, 32767, 255, 0), 1'b0);
        send_sample(5, 0, 0);
        send_sample(10, 0, 0);
        send_sample(4, 0, 0);
        send_sample(3, 0, 0);
        send_sample(100, 0, 0);
        send_sample(-7, 0, 0);
    endtask

    // grow the integral with the widest error, back to back, then clear it
    task automatic test_integral_growth();
        reconfigure(make_cfg(65535, 0, 65535, 0, 32767, 200, 0), 1'b0);
        tx_paced = 1'b0;
        rx_free  = 1'b1;
        for (int n = 0; n < GROW_ITEMS; n++) begin
            send_sample(POS_MAX, POS_MIN, 0);
        end
        send_sample(4, 0, 0);
        send_sample(0, 0, 0);
        reconfigure(make_cfg(0, 0, 1, 0, 32767, 255, 0), 1'b0);
        for (int n = 0; n < GROW_ITEMS; n++) begin
            send_sample(POS_MAX, POS_MIN, 0);
        end
        send_sample(1000, 0, 0);
        send_sample(-1, 0, 0);
        finish_stream();
        wait_drained();
        rx_free  = 1'b0;
        tx_paced = 1'b1;
    endtask

    // hold the receiver off while samples keep coming, so the input stalls
    task automatic test_backpressure();
        logic signed [POS_W-1:0]   tgt, pos;
        logic signed [SPEED_W-1:0] spd;
        reconfigure(rand_cfg(), 1'b1);
        tx_paced = 1'b0;
        rx_hold  = HOLD_OFF_CYCLES;
        for (int n = 0; n < 48; n++) begin
            rand_sample(tgt, pos, spd);
            send_sample(tgt, pos, spd);
        end
        tx_paced = 1'b1;
    endtask

    // random phases: extreme settings first, then random ones
    task automatic test_random_phases();
        logic signed [POS_W-1:0]   tgt, pos;
        logic signed [SPEED_W-1:0] spd;
        t_cfg c;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       c = make_cfg(65535, 65535, 65535, 65535, 32767, 255, 1);
                1:       c = make_cfg(0, 0, 0, 0, 0, 255, 0);
                default: c = rand_cfg();
            endcase
            reconfigure(c, ph[0]);
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                rand_sample(tgt, pos, spd);
                send_sample(tgt, pos, spd);
            end
        end
    endtask

    initial begin : run_tests
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        smp.valid          = 1'b0;
        smp.target_pos     = '0;
        smp.measured_pos   = '0;
        smp.measured_speed = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_prop_term();
        test_damping_term();
        test_overspeed_term();
        test_integral_clear();
        test_integral_growth();
        test_backpressure();
        test_random_phases();

        finish_stream();
        wait_drained();
        $display("covered %0d samples and %0d drive beats over %0d register settings",
                 samples_sent, drives_checked, configs_written);
        $display("incl. integral growth, receiver hold-off and random pacing; %0d errors",
                 failures);
        if (failures == 0) begin
            $display("pid_motor_drive_with_speed_limit_test: PASS");
        end else begin
            $display("pid_motor_drive_with_speed_limit_test: FAIL");
        end
        $finish;
    end
endmodule
